### rtl/iqdd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// iqdd_pkg
// Shared types, constants and fixed-point helpers of the I/Q downconverter
// and demodulator.
// ---------------------------------------------------------------------------
package iqdd_pkg;

    // Default sizes
    localparam int SAMPLE_WIDTH_DEF     = 16;
    localparam int STATE_WIDTH_DEF      = 24;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;

    // Oscillator and discriminator constants
    localparam int CORDIC_STAGES = 16;
    localparam int CORDIC_W      = 34;
    localparam int TRIG_W        = 16;
    localparam int TRIG_FRAC     = 15;
    localparam int FM_WIDTH      = 24;
    localparam int FM_PROD_W     = 2 * FM_WIDTH;
    localparam int NUM_W         = FM_PROD_W + 1;
    localparam int GAIN_W        = 16;
    localparam int ALPHA_W       = 17;
    localparam int DECIM_W       = 11;
    localparam int CNT_W         = 10;
    localparam int STEP_W        = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;
    localparam logic [ALPHA_W-1:0] ALPHA_MAX = 17'd65536;
    localparam logic [DECIM_W-1:0] DECIM_MAX = 11'd1024;

    localparam logic signed [CORDIC_W-1:0] ATAN_TURNS [CORDIC_STAGES] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
        34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
        34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861
    };

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECIMATION   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FM_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEMOD_MODE   = 3'd4;

    // Demodulation modes
    localparam logic [1:0] MODE_FM  = 2'd0;
    localparam logic [1:0] MODE_AM  = 2'd1;
    localparam logic [1:0] MODE_SSB = 2'd2;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_ROT,
        OP_MIX,
        OP_FMP,
        OP_AMP,
        OP_DIV,
        OP_SQRT,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [STEP_W-1:0] step;
        logic             out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic       keep;
        logic [1:0] mode;
    } dp_status_t;

    // Shift left by lsh, or round half up and shift right by rsh
    function automatic logic signed [63:0] rescale64(input logic signed [63:0] v,
                                                     input int lsh, input int rsh);
        logic signed [63:0] rnd;
        rnd = (64'sd1 <<< rsh) >>> 1;
        return ((v <<< lsh) + rnd) >>> rsh;
    endfunction

    // Saturate to a signed w-bit range
    function automatic logic signed [63:0] sat64(input logic signed [63:0] v, input int w);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/iq_downconvert_demodulator.sv
`default_nettype none
// ---------------------------------------------------------------------------
// iq_downconvert_demodulator
// NCO downconversion, one-pole IIR low-pass, decimation and FM/AM/SSB
// demodulation of a signed I/Q stream.
//
//   channel  direction  handshake          payload
//   in       sink       in_valid/in_stall  i_sample, q_sample, record_last
//   out      source     out_valid/out_stall audio_sample
//   cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// A pair runs through the 16-step CORDIC and the shared multiplier schedule,
// then through the bit-serial divider in FM mode or the bit-serial square
// root in AM mode; a dropped pair or SSB mode goes straight to the finish.
// One pair is in work at a time.
// A finished result waits in the output register while the next pair runs;
// only a new result meeting a stalled full register holds the sequencer.
// Reset clears the oscillator, filters, decimation counter and valid flag.
// ---------------------------------------------------------------------------
module iq_downconvert_demodulator
    import iqdd_pkg::*;
#(
    parameter int SAMPLE_WIDTH     = SAMPLE_WIDTH_DEF,
    parameter int STATE_WIDTH      = STATE_WIDTH_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic signed [SAMPLE_WIDTH-1:0] q_sample,
    input  wire logic                           record_last,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]      audio_sample,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [CFG_DATA_W-1:0]          cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    iqdd_ctrl #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .STATE_WIDTH  (STATE_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    iqdd_datapath #(
        .SAMPLE_WIDTH     (SAMPLE_WIDTH),
        .STATE_WIDTH      (STATE_WIDTH),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .i_sample     (i_sample),
        .q_sample     (q_sample),
        .record_last  (record_last),
        .audio_sample (audio_sample)
    );

`ifndef SYNTHESIS
    // A load happens only on an accepted transaction
    a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_LOAD) |-> (in_valid && !in_stall))
        else $error("datapath load without accepted input transaction");

    // The block is busy right after accepting a pair
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted twice in a row");

    // Never overwrite a result that is still stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FINISH && cmd.out_load) |-> !(out_valid && out_stall))
        else $error("output register overwritten while stalled");
`endif

endmodule
`default_nettype wire

### rtl/iqdd_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// iqdd_ctrl
// Sequencer: accepts a pair, steps the datapath through rotation, mixing,
// filtering and demodulation, and hands the result to the output register.
// ---------------------------------------------------------------------------
module iqdd_ctrl
    import iqdd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int STATE_WIDTH  = STATE_WIDTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_ROT  = 8'b0000_0010,
        S_MIX  = 8'b0000_0100,
        S_FMP  = 8'b0000_1000,
        S_AMP  = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_SQRT = 8'b0100_0000,
        S_FIN  = 8'b1000_0000
    } state_t;

    localparam logic [STEP_W-1:0] ROT_LAST  = STEP_W'(CORDIC_STAGES - 1);
    localparam logic [STEP_W-1:0] MIX_LAST  = STEP_W'(7);
    localparam logic [STEP_W-1:0] FMP_LAST  = STEP_W'(7);
    localparam logic [STEP_W-1:0] AMP_LAST  = STEP_W'(2);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SAMPLE_WIDTH - 2);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(STATE_WIDTH - 1);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              load;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // Sequence the datapath
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg + STEP_W'(1);
        cmd.op       = OP_IDLE;
        cmd.step     = step_reg;
        cmd.out_load = 1'b0;
        load         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                step_next = '0;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                cmd.op = OP_ROT;
                if (step_reg == ROT_LAST)
                begin
                    state_next = S_MIX;
                    step_next  = '0;
                end
            end
            S_MIX:
            begin
                cmd.op = OP_MIX;
                if (step_reg == MIX_LAST)
                begin
                    step_next = '0;
                    if (!status.keep)
                        state_next = S_FIN;
                    else if (status.mode == MODE_FM)
                        state_next = S_FMP;
                    else if (status.mode == MODE_AM)
                        state_next = S_AMP;
                    else
                        state_next = S_FIN;
                end
            end
            S_FMP:
            begin
                cmd.op = OP_FMP;
                if (step_reg == FMP_LAST)
                begin
                    state_next = S_DIV;
                    step_next  = '0;
                end
            end
            S_DIV:
            begin
                cmd.op = OP_DIV;
                if (step_reg == DIV_LAST)
                begin
                    state_next = S_FIN;
                    step_next  = '0;
                end
            end
            S_AMP:
            begin
                cmd.op = OP_AMP;
                if (step_reg == AMP_LAST)
                begin
                    state_next = S_SQRT;
                    step_next  = '0;
                end
            end
            S_SQRT:
            begin
                cmd.op = OP_SQRT;
                if (step_reg == SQRT_LAST)
                begin
                    state_next = S_FIN;
                    step_next  = '0;
                end
            end
            S_FIN:
            begin
                step_next = '0;
                // Hold a kept result while a stalled one still occupies the output register
                if (!status.keep || !(out_valid_reg && out_stall))
                begin
                    cmd.op       = OP_FINISH;
                    cmd.out_load = status.keep;
                    load         = status.keep;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && out_stall) || load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

### rtl/iqdd_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// iqdd_datapath
// Configuration registers, NCO with iterative CORDIC, shared multiplier,
// IIR filters, decimation counter, FM divider, AM square root, output register.
// ---------------------------------------------------------------------------
module iqdd_datapath
    import iqdd_pkg::*;
#(
    parameter int SAMPLE_WIDTH     = SAMPLE_WIDTH_DEF,
    parameter int STATE_WIDTH      = STATE_WIDTH_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire dp_cmd_t                        cmd,
    output dp_status_t                          status,
    input  wire logic                           cfg_we,
    input  wire logic [CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [CFG_DATA_W-1:0]          cfg_data,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic signed [SAMPLE_WIDTH-1:0] q_sample,
    input  wire logic                           record_last,
    output logic signed [SAMPLE_WIDTH-1:0]      audio_sample
);

    localparam int SAMW = SAMPLE_WIDTH;
    localparam int STW  = STATE_WIDTH;
    localparam int SQW  = 2 * STW;
    localparam int MW   = (STW + 1 > 26) ? STW + 1 : 26;
    localparam int PW   = 2 * MW;
    localparam int TB   = $clog2(SINE_TABLE_DEPTH + 1) - 1;
    localparam int SF   = STW - 2;
    localparam int INF  = SAMW - 1;
    localparam int PF   = INF + TRIG_FRAC;
    localparam int MIX_L = (SF >= PF) ? SF - PF : 0;
    localparam int MIX_R = (SF >= PF) ? 0 : PF - SF;
    localparam int OUT_L = (INF >= SF) ? INF - SF : 0;
    localparam int OUT_R = (INF >= SF) ? 0 : SF - INF;
    localparam int FM_L  = (FM_WIDTH >= STW) ? FM_WIDTH - STW : 0;
    localparam int FM_R  = (FM_WIDTH >= STW) ? 0 : STW - FM_WIDTH;
    localparam int HALF  = FM_PROD_W / 2;
    localparam logic [31:0] ANG_MASK = ~((32'd1 << (32 - TB)) - 32'd1);
    localparam logic signed [STW-1:0] PREV_I_RST = STW'(64'sd1 <<< SF);
    localparam logic [SQW-1:0] SQ_BIT0 = SQW'(1) << (SQW - 2);

    // Configuration
    logic signed [31:0]       phase_step_reg;
    logic [ALPHA_W-1:0]       alpha_reg;
    logic [DECIM_W-1:0]       decim_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic [1:0]               mode_reg;

    // Item state
    logic [31:0]              phase_reg, phase_next;
    logic signed [STW-1:0]    fi_reg, fi_next, fq_reg, fq_next;
    logic signed [STW-1:0]    pi_reg, pi_next, pq_reg, pq_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    // Working registers
    logic signed [SAMW-1:0]     i_reg, i_next, q_reg, q_next;
    logic                       last_reg, last_next, flip_reg, flip_next;
    logic signed [CORDIC_W-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic signed [TRIG_W-1:0]   c_reg, c_next, s_reg, s_next;
    logic signed [PW-1:0]       prod_reg, prod_next, acc_reg, acc_next;
    logic signed [STW-1:0]      mi_reg, mi_next, mq_reg, mq_next;
    logic signed [NUM_W-1:0]    num_reg, num_next;
    logic [FM_PROD_W-1:0]       den_reg, den_next;
    logic [63:0]                rem_reg, rem_next;
    logic                       ovf_reg, ovf_next;
    logic [SAMW-2:0]            quo_reg, quo_next;
    logic [SQW-1:0]             sqn_reg, sqn_next, sqr_reg, sqr_next, sqb_reg, sqb_next;
    logic signed [SAMW-1:0]     audio_reg, audio_next;

    // Combinational terms
    logic [31:0]                angle_w, angle_f_w;
    logic                       flip_w;
    logic [3:0]                 sh_w;
    logic signed [CORDIC_W-1:0] xs_w, ys_w, xf_w, yf_w;
    logic signed [TRIG_W-1:0]   cos_w, sin_w;
    logic signed [MW-1:0]       mul_a, mul_b;
    logic signed [STW-1:0]      mi_w, mq_w, fi_upd_w, fq_upd_w;
    logic signed [STW:0]        di_w, dq_w;
    logic [ALPHA_W-1:0]         a_eff_w;
    logic signed [FM_WIDTH-1:0] ci_w, cq_w, pi_w, pq_w;
    logic [FM_PROD_W-2:0]       nmag_w;
    logic [63:0]                d2_w, r2_w;
    logic [SQW-1:0]             sq_sum_w;
    logic [DECIM_W-1:0]         dec_eff_w, cnt_inc_w;
    logic [CNT_W-1:0]           cnt_wrap_w;
    logic signed [SAMW-1:0]     fm_w, am_w, ssb_w, result_w;

    // Oscillator angle and quadrant fold
    assign angle_w   = phase_reg & ANG_MASK;
    assign flip_w    = angle_w[31] ^ angle_w[30];
    assign angle_f_w = {angle_w[31] ^ flip_w, angle_w[30:0]};

    // CORDIC micro-rotation terms
    assign sh_w = cmd.step[3:0];
    assign xs_w = x_reg >>> sh_w;
    assign ys_w = y_reg >>> sh_w;
    assign xf_w = flip_reg ? -x_reg : x_reg;
    assign yf_w = flip_reg ? -y_reg : y_reg;
    assign cos_w = TRIG_W'(sat64(rescale64(64'(xf_w), 0, 30 - TRIG_FRAC), TRIG_W));
    assign sin_w = TRIG_W'(sat64(rescale64(64'(yf_w), 0, 30 - TRIG_FRAC), TRIG_W));

    // Mixer and filter terms
    assign mi_w = STW'(sat64(rescale64(64'(acc_reg - prod_reg), MIX_L, MIX_R), STW));
    assign mq_w = STW'(sat64(rescale64(64'(acc_reg + prod_reg), MIX_L, MIX_R), STW));
    assign di_w = (STW + 1)'(mi_reg) - (STW + 1)'(fi_reg);
    assign dq_w = (STW + 1)'(mq_reg) - (STW + 1)'(fq_reg);
    assign a_eff_w = (alpha_reg > ALPHA_MAX) ? ALPHA_MAX : alpha_reg;
    assign fi_upd_w = STW'(sat64(64'(fi_reg) + ((64'(prod_reg) + 64'sd32768) >>> 16), STW));
    assign fq_upd_w = STW'(sat64(64'(fq_reg) + ((64'(prod_reg) + 64'sd32768) >>> 16), STW));

    // Decimation
    assign dec_eff_w  = (decim_reg == '0) ? DECIM_W'(1) :
                        ((decim_reg > DECIM_MAX) ? DECIM_MAX : decim_reg);
    assign cnt_inc_w  = DECIM_W'(cnt_reg) + DECIM_W'(1);
    assign cnt_wrap_w = (cnt_inc_w >= dec_eff_w) ? '0 : cnt_inc_w[CNT_W-1:0];

    // Discriminator inputs reduced to the FM width
    assign ci_w = FM_WIDTH'((64'(fi_reg) <<< FM_L) >>> FM_R);
    assign cq_w = FM_WIDTH'((64'(fq_reg) <<< FM_L) >>> FM_R);
    assign pi_w = FM_WIDTH'((64'(pi_reg) <<< FM_L) >>> FM_R);
    assign pq_w = FM_WIDTH'((64'(pq_reg) <<< FM_L) >>> FM_R);
    assign nmag_w = num_reg[NUM_W-1] ? (FM_PROD_W - 1)'(-num_reg)
                                     : (FM_PROD_W - 1)'(num_reg);
    assign d2_w = 64'({den_reg, 8'd0});
    assign r2_w = rem_reg << 1;

    assign sq_sum_w = sqr_reg + sqb_reg;

    // Output selection
    always_comb
    begin
        if (den_reg == '0)
            fm_w = '0;
        else if (ovf_reg)
            fm_w = num_reg[NUM_W-1] ? {1'b1, {(SAMW - 1){1'b0}}} : {1'b0, {(SAMW - 1){1'b1}}};
        else if (num_reg[NUM_W-1])
            fm_w = -SAMW'(quo_reg);
        else
            fm_w = SAMW'(quo_reg);
    end
    assign am_w  = SAMW'(sat64(rescale64(64'(sqr_reg), OUT_L, OUT_R), SAMW));
    assign ssb_w = SAMW'(sat64(rescale64(64'(fi_reg), OUT_L, OUT_R), SAMW));

    always_comb
    begin
        case (mode_reg)
            MODE_FM:  result_w = fm_w;
            MODE_AM:  result_w = am_w;
            MODE_SSB: result_w = ssb_w;
            default:  result_w = '0;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Operation decode
    always_comb
    begin
        phase_next = phase_reg;
        fi_next    = fi_reg;
        fq_next    = fq_reg;
        pi_next    = pi_reg;
        pq_next    = pq_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        q_next     = q_reg;
        last_next  = last_reg;
        flip_next  = flip_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        c_next     = c_reg;
        s_next     = s_reg;
        acc_next   = acc_reg;
        mi_next    = mi_reg;
        mq_next    = mq_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        ovf_next   = ovf_reg;
        quo_next   = quo_reg;
        sqn_next   = sqn_reg;
        sqr_next   = sqr_reg;
        sqb_next   = sqb_reg;
        audio_next = audio_reg;
        mul_a      = '0;
        mul_b      = '0;
        unique case (cmd.op)
            OP_LOAD:
            begin
                i_next     = i_sample;
                q_next     = q_sample;
                last_next  = record_last;
                flip_next  = flip_w;
                x_next     = CORDIC_X0;
                y_next     = '0;
                z_next     = CORDIC_W'(signed'(angle_f_w));
                phase_next = phase_reg + phase_step_reg;
            end
            OP_ROT:
            begin
                if (!z_reg[CORDIC_W-1])
                begin
                    x_next = x_reg - ys_w;
                    y_next = y_reg + xs_w;
                    z_next = z_reg - ATAN_TURNS[sh_w];
                end
                else
                begin
                    x_next = x_reg + ys_w;
                    y_next = y_reg - xs_w;
                    z_next = z_reg + ATAN_TURNS[sh_w];
                end
            end
            OP_MIX:
            begin
                case (cmd.step[2:0])
                    3'd0:
                    begin
                        c_next = cos_w;
                        s_next = sin_w;
                    end
                    3'd1:
                    begin
                        mul_a = MW'(i_reg);
                        mul_b = MW'(c_reg);
                    end
                    3'd2:
                    begin
                        mul_a    = MW'(q_reg);
                        mul_b    = MW'(s_reg);
                        acc_next = prod_reg;
                    end
                    3'd3:
                    begin
                        mul_a   = MW'(i_reg);
                        mul_b   = MW'(s_reg);
                        mi_next = mi_w;
                    end
                    3'd4:
                    begin
                        mul_a    = MW'(q_reg);
                        mul_b    = MW'(c_reg);
                        acc_next = prod_reg;
                    end
                    3'd5:
                    begin
                        mq_next = mq_w;
                        mul_a   = MW'(di_w);
                        mul_b   = MW'(a_eff_w);
                    end
                    3'd6:
                    begin
                        fi_next = fi_upd_w;
                        mul_a   = MW'(dq_w);
                        mul_b   = MW'(a_eff_w);
                    end
                    default:
                    begin
                        fq_next = fq_upd_w;
                    end
                endcase
            end
            OP_FMP:
            begin
                case (cmd.step[2:0])
                    3'd0:
                    begin
                        mul_a = MW'(ci_w);
                        mul_b = MW'(pq_w);
                    end
                    3'd1:
                    begin
                        mul_a    = MW'(cq_w);
                        mul_b    = MW'(pi_w);
                        acc_next = prod_reg;
                    end
                    3'd2:
                    begin
                        mul_a    = MW'(ci_w);
                        mul_b    = MW'(ci_w);
                        num_next = NUM_W'(acc_reg - prod_reg);
                    end
                    3'd3:
                    begin
                        mul_a    = MW'(cq_w);
                        mul_b    = MW'(cq_w);
                        acc_next = prod_reg;
                    end
                    3'd4:
                    begin
                        den_next = FM_PROD_W'(acc_reg + prod_reg);
                        mul_a    = MW'(nmag_w[HALF-1:0]);
                        mul_b    = MW'(gain_reg);
                    end
                    3'd5:
                    begin
                        mul_a    = MW'(nmag_w[FM_PROD_W-2:HALF]);
                        mul_b    = MW'(gain_reg);
                        acc_next = prod_reg;
                    end
                    3'd6:
                    begin
                        rem_next = 64'(acc_reg) + (64'(prod_reg) << HALF);
                    end
                    default:
                    begin
                        ovf_next = (rem_reg >= d2_w);
                        quo_next = '0;
                    end
                endcase
            end
            OP_DIV:
            begin
                // One quotient bit per cycle
                if (r2_w >= d2_w)
                begin
                    rem_next = r2_w - d2_w;
                    quo_next = {quo_reg[SAMW-3:0], 1'b1};
                end
                else
                begin
                    rem_next = r2_w;
                    quo_next = {quo_reg[SAMW-3:0], 1'b0};
                end
            end
            OP_AMP:
            begin
                case (cmd.step[1:0])
                    2'd0:
                    begin
                        mul_a = MW'(fi_reg);
                        mul_b = MW'(fi_reg);
                    end
                    2'd1:
                    begin
                        mul_a    = MW'(fq_reg);
                        mul_b    = MW'(fq_reg);
                        acc_next = prod_reg;
                    end
                    default:
                    begin
                        sqn_next = SQW'(acc_reg + prod_reg);
                        sqr_next = '0;
                        sqb_next = SQ_BIT0;
                    end
                endcase
            end
            OP_SQRT:
            begin
                // One root bit per cycle
                if (sqn_reg >= sq_sum_w)
                begin
                    sqn_next = sqn_reg - sq_sum_w;
                    sqr_next = (sqr_reg >> 1) + sqb_reg;
                end
                else
                begin
                    sqr_next = sqr_reg >> 1;
                end
                sqb_next = sqb_reg >> 2;
            end
            OP_FINISH:
            begin
                if (cmd.out_load)
                    audio_next = result_w;
                if (cnt_reg == '0)
                begin
                    pi_next = fi_reg;
                    pq_next = fq_reg;
                end
                cnt_next = cnt_wrap_w;
                // Return to the record start state after the last pair
                if (last_reg)
                begin
                    phase_next = '0;
                    fi_next    = '0;
                    fq_next    = '0;
                    cnt_next   = '0;
                    pi_next    = PREV_I_RST;
                    pq_next    = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Configuration and record state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
            alpha_reg      <= ALPHA_MAX;
            decim_reg      <= DECIM_W'(1);
            gain_reg       <= GAIN_W'(256);
            mode_reg       <= MODE_FM;
            phase_reg      <= '0;
            fi_reg         <= '0;
            fq_reg         <= '0;
            pi_reg         <= PREV_I_RST;
            pq_reg         <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            fi_reg    <= fi_next;
            fq_reg    <= fq_next;
            pi_reg    <= pi_next;
            pq_reg    <= pq_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PHASE_STEP:   phase_step_reg <= cfg_data;
                    CFG_FILTER_ALPHA: alpha_reg      <= cfg_data[ALPHA_W-1:0];
                    CFG_DECIMATION:   decim_reg      <= cfg_data[DECIM_W-1:0];
                    CFG_FM_GAIN:      gain_reg       <= cfg_data[GAIN_W-1:0];
                    CFG_DEMOD_MODE:   mode_reg       <= cfg_data[1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        q_reg     <= q_next;
        last_reg  <= last_next;
        flip_reg  <= flip_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        c_reg     <= c_next;
        s_reg     <= s_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        mi_reg    <= mi_next;
        mq_reg    <= mq_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        ovf_reg   <= ovf_next;
        quo_reg   <= quo_next;
        sqn_reg   <= sqn_next;
        sqr_reg   <= sqr_next;
        sqb_reg   <= sqb_next;
        audio_reg <= audio_next;
    end

    assign status.keep   = (cnt_reg == '0);
    assign status.mode   = mode_reg;
    assign audio_sample  = audio_reg;

endmodule
`default_nettype wire
